// ===== design/dxt1_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt1_pkg
// Types and constants shared by the DXT1 block decoder pipeline.
// ----------------------------------------------------------------------------
package dxt1_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned TABLE_W  = 32;
  localparam int unsigned COLOR_W  = 16;

  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [ROW_W-1:0]   LAST_ROW_NUM = 2'd3;
  localparam logic [PIXEL_W-1:0] PIXEL_CLEAR  = 32'h0000_0000;

  // one expanded color, byte0 in ch_hi, byte2 in ch_lo
  typedef struct packed {
    logic [CHAN_W-1:0] ch_lo;
    logic [CHAN_W-1:0] ch_g;
    logic [CHAN_W-1:0] ch_hi;
  } rgb8_t;

  // raw compressed block
  typedef struct packed {
    logic [COLOR_W-1:0] endpoint_a;
    logic [COLOR_W-1:0] endpoint_b;
    logic [TABLE_W-1:0] index_table;
  } blk_t;

  // endpoints after channel expansion
  typedef struct packed {
    rgb8_t              col_a;
    rgb8_t              col_b;
    logic               four_color;
    logic [TABLE_W-1:0] index_table;
  } exp_t;

  // full palette plus selectors
  typedef struct packed {
    logic [NUM_COLS-1:0][PIXEL_W-1:0] pal;
    logic [TABLE_W-1:0]               index_table;
  } pal_t;

endpackage

// ===== design/dxt1_in_if.sv =====
// ----------------------------------------------------------------------------
// dxt1_in_if
// Request channel carrying one compressed 4x4 block.
// ----------------------------------------------------------------------------
interface dxt1_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_a;
  logic [15:0] endpoint_b;
  logic [31:0] index_table;

  modport source (output valid, output endpoint_a, output endpoint_b,
                  output index_table, input ready);
  modport sink   (input valid, input endpoint_a, input endpoint_b,
                  input index_table, output ready);
endinterface

// ===== design/dxt1_out_if.sv =====
// ----------------------------------------------------------------------------
// dxt1_out_if
// Result channel carrying one decoded row of four pixels.
// ----------------------------------------------------------------------------
interface dxt1_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_number;
  logic [31:0] pixel_col0;
  logic [31:0] pixel_col1;
  logic [31:0] pixel_col2;
  logic [31:0] pixel_col3;
  logic        last_row;

  modport source (output valid, output row_number, output pixel_col0,
                  output pixel_col1, output pixel_col2, output pixel_col3,
                  output last_row, input ready);
  modport sink   (input valid, input row_number, input pixel_col0,
                  input pixel_col1, input pixel_col2, input pixel_col3,
                  input last_row, output ready);
endinterface

// ===== design/dxt1_expand.sv =====
// ----------------------------------------------------------------------------
// dxt1_expand
// Input register and RGB565 to 8-bit channel expansion (two stages).
// ----------------------------------------------------------------------------
module dxt1_expand (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dxt1_pkg::blk_t up_blk,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dxt1_pkg::exp_t dn_exp
);

  // v*255/31 as (v*255 * 8457) >> 18, exact for every 5-bit v
  localparam logic [13:0] RECIP31 = 14'd8457;
  // v*255/63 as (v*255 * 16645) >> 20, exact for every 6-bit v
  localparam logic [14:0] RECIP63 = 15'd16645;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    begin
      x = {v, 8'b0} - {8'b0, v};
      p = {14'b0, x} * {13'b0, RECIP31};
      expand5 = p[25:18];
    end
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    begin
      x = {v, 8'b0} - {8'b0, v};
      p = {15'b0, x} * {14'b0, RECIP63};
      expand6 = p[27:20];
    end
  endfunction

  function automatic dxt1_pkg::rgb8_t expand565(input logic [15:0] c);
    dxt1_pkg::rgb8_t r;
    begin
      r.ch_hi   = expand5(c[15:11]);
      r.ch_g    = expand6(c[10:5]);
      r.ch_lo   = expand5(c[4:0]);
      expand565 = r;
    end
  endfunction

  logic           a_valid_r;
  dxt1_pkg::blk_t a_blk_r;
  logic           a_ready;
  logic           b_valid_r;
  dxt1_pkg::exp_t b_exp_r;
  dxt1_pkg::exp_t b_exp_nxt;
  logic           b_ready;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_comb begin
    b_exp_nxt.col_a       = expand565(a_blk_r.endpoint_a);
    b_exp_nxt.col_b       = expand565(a_blk_r.endpoint_b);
    b_exp_nxt.four_color  = a_blk_r.endpoint_a > a_blk_r.endpoint_b;
    b_exp_nxt.index_table = a_blk_r.index_table;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_blk_r <= up_blk;
    end
    if (b_ready && a_valid_r) begin
      b_exp_r <= b_exp_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_exp   = b_exp_r;

endmodule

// ===== design/dxt1_interp.sv =====
// ----------------------------------------------------------------------------
// dxt1_interp
// Palette build: endpoint pass-through and per-channel interpolation.
// ----------------------------------------------------------------------------
module dxt1_interp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dxt1_pkg::exp_t up_exp,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dxt1_pkg::pal_t dn_pal
);

  // x/3 as (x * 683) >> 11, exact for x below 2048
  localparam logic [9:0] RECIP3 = 10'd683;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    begin
      p    = {10'b0, x} * {10'b0, RECIP3};
      div3 = p[18:11];
    end
  endfunction

  // weighted sums of one channel: 2a+b, a+2b and a+b
  function automatic logic [7:0] third_near(input logic [7:0] p, input logic [7:0] q);
    logic [9:0] s;
    begin
      s          = {1'b0, p, 1'b0} + {2'b0, q};
      third_near = div3(s);
    end
  endfunction

  function automatic logic [7:0] half(input logic [7:0] p, input logic [7:0] q);
    logic [8:0] s;
    begin
      s    = {1'b0, p} + {1'b0, q};
      half = s[8:1];
    end
  endfunction

  logic           c_valid_r;
  dxt1_pkg::pal_t c_pal_r;
  dxt1_pkg::pal_t c_pal_nxt;
  logic           c_ready;
  dxt1_pkg::rgb8_t mix2, mix3;

  assign c_ready  = !c_valid_r || dn_ready;
  assign up_ready = c_ready;

  always_comb begin
    if (up_exp.four_color) begin
      mix2.ch_hi = third_near(up_exp.col_a.ch_hi, up_exp.col_b.ch_hi);
      mix2.ch_g  = third_near(up_exp.col_a.ch_g,  up_exp.col_b.ch_g);
      mix2.ch_lo = third_near(up_exp.col_a.ch_lo, up_exp.col_b.ch_lo);
    end else begin
      mix2.ch_hi = half(up_exp.col_a.ch_hi, up_exp.col_b.ch_hi);
      mix2.ch_g  = half(up_exp.col_a.ch_g,  up_exp.col_b.ch_g);
      mix2.ch_lo = half(up_exp.col_a.ch_lo, up_exp.col_b.ch_lo);
    end
    mix3.ch_hi = third_near(up_exp.col_b.ch_hi, up_exp.col_a.ch_hi);
    mix3.ch_g  = third_near(up_exp.col_b.ch_g,  up_exp.col_a.ch_g);
    mix3.ch_lo = third_near(up_exp.col_b.ch_lo, up_exp.col_a.ch_lo);

    c_pal_nxt.pal[0] = {dxt1_pkg::ALPHA_OPAQUE, up_exp.col_a};
    c_pal_nxt.pal[1] = {dxt1_pkg::ALPHA_OPAQUE, up_exp.col_b};
    c_pal_nxt.pal[2] = {dxt1_pkg::ALPHA_OPAQUE, mix2};
    // three-color mode: index 3 is transparent black
    c_pal_nxt.pal[3] = up_exp.four_color ? {dxt1_pkg::ALPHA_OPAQUE, mix3}
                                         : dxt1_pkg::PIXEL_CLEAR;
    c_pal_nxt.index_table = up_exp.index_table;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && up_valid) begin
      c_pal_r <= c_pal_nxt;
    end
  end

  assign dn_valid = c_valid_r;
  assign dn_pal   = c_pal_r;

endmodule

// ===== design/dxt1_row_emit.sv =====
// ----------------------------------------------------------------------------
// dxt1_row_emit
// Output stage: holds one palette and sends the block out row by row.
// ----------------------------------------------------------------------------
module dxt1_row_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dxt1_pkg::pal_t up_pal,
  dxt1_out_if.source     out_chan
);

  localparam int unsigned ROW_SEL_W = dxt1_pkg::NUM_COLS * dxt1_pkg::SEL_W;

  logic                                             d_valid_r;
  logic [dxt1_pkg::NUM_COLS-1:0][dxt1_pkg::PIXEL_W-1:0] d_pal_r;
  logic [dxt1_pkg::TABLE_W-1:0]                     d_tab_r;
  logic [dxt1_pkg::ROW_W-1:0]                       d_row_r;
  logic                                             is_last;
  logic                                             out_take;
  logic                                             load;
  logic [dxt1_pkg::NUM_COLS-1:0][dxt1_pkg::PIXEL_W-1:0] row_pix;

  assign is_last  = d_row_r == dxt1_pkg::LAST_ROW_NUM;
  assign out_take = d_valid_r && out_chan.ready;
  assign up_ready = !d_valid_r || (out_chan.ready && is_last);
  assign load     = up_valid && up_ready;

  // current row's selectors always sit in the low byte of d_tab_r
  always_comb begin
    for (int x = 0; x < dxt1_pkg::NUM_COLS; x++) begin
      row_pix[x] = d_pal_r[d_tab_r[x*dxt1_pkg::SEL_W +: dxt1_pkg::SEL_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      d_row_r   <= '0;
    end else if (load) begin
      d_valid_r <= 1'b1;
      d_row_r   <= '0;
    end else if (out_take) begin
      d_valid_r <= !is_last;
      d_row_r   <= d_row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_pal_r <= up_pal.pal;
      d_tab_r <= up_pal.index_table;
    end else if (out_take) begin
      d_tab_r <= d_tab_r >> ROW_SEL_W;
    end
  end

  assign out_chan.valid      = d_valid_r;
  assign out_chan.row_number = d_row_r;
  assign out_chan.pixel_col0 = row_pix[0];
  assign out_chan.pixel_col1 = row_pix[1];
  assign out_chan.pixel_col2 = row_pix[2];
  assign out_chan.pixel_col3 = row_pix[3];
  assign out_chan.last_row   = is_last;

endmodule

// ===== design/dxt1_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dxt1_block_decoder_unit
// DXT1 (BC1) block decoder: one 4x4 block in, four rows of RGBA8 pixels out.
// ----------------------------------------------------------------------------
// A block accepted on in_chan passes the input register, the channel expansion
// stage, the palette stage and the output stage before its first row shows on
// out_chan. The output stage then sends rows 0 to 3 on consecutive cycles
// while out_chan.ready stays high, handing out one row per cycle, and this
// output stage sets the sustained rate of the decoder.
// Up to three further blocks wait in the stages behind it; back pressure
// holds every stage without losing or repeating a request.
module dxt1_block_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  dxt1_in_if.sink    in_chan,
  dxt1_out_if.source out_chan
);

  dxt1_pkg::blk_t in_blk;
  logic           exp_valid;
  logic           exp_ready;
  dxt1_pkg::exp_t exp_data;
  logic           pal_valid;
  logic           pal_ready;
  dxt1_pkg::pal_t pal_data;

  assign in_blk.endpoint_a  = in_chan.endpoint_a;
  assign in_blk.endpoint_b  = in_chan.endpoint_b;
  assign in_blk.index_table = in_chan.index_table;

  dxt1_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_blk   (in_blk),
    .dn_valid (exp_valid),
    .dn_ready (exp_ready),
    .dn_exp   (exp_data)
  );

  dxt1_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (exp_valid),
    .up_ready (exp_ready),
    .up_exp   (exp_data),
    .dn_valid (pal_valid),
    .dn_ready (pal_ready),
    .dn_pal   (pal_data)
  );

  dxt1_row_emit u_row_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pal_valid),
    .up_ready (pal_ready),
    .up_pal   (pal_data),
    .out_chan (out_chan)
  );

endmodule
